[design/dg_advection_euler_step_core_defines.svh]
// Assertion macros for the advection step core.
// Included by the RTL files that carry concurrent checks; needs no other file.
`ifndef DG_ADVECTION_EULER_STEP_CORE_DEFINES_SVH
`define DG_ADVECTION_EULER_STEP_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define DGADV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DGADV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DGADV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DGADV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[design/dgadv_pkg.sv]
// Shared types, widths and codes of the advection step core.
// Used by the cell, the update datapath and the top level; depends on nothing.
package dgadv_pkg;

    localparam int DEFAULT_ELEMENTS = 32;

    localparam int CMD_W       = 2;
    localparam int CELL_W      = 5;
    localparam int COEF_W      = 16;
    localparam int VEL_W       = 16;
    localparam int TS_W        = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 32;

    // Datapath widths: S = 2P - L - R, D = L - R, X = 2S - D or 2D - S.
    localparam int S_W         = 18;
    localparam int D_W         = 17;
    localparam int X_W         = 20;
    localparam int K_W         = 33;
    localparam int PROD_W      = 53;
    localparam int ROUND_SHIFT = 36;
    localparam int INC_W       = PROD_W - ROUND_SHIFT;
    localparam int SUM_W       = 18;

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (ROUND_SHIFT - 1);

    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_VELOCITY  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIME_STEP = 2'd1;

    localparam logic signed [VEL_W-1:0] VELOCITY_RESET  = 16'sd768;
    localparam logic        [TS_W-1:0]  TIME_STEP_RESET = 16'd655;

    typedef struct packed {
        logic signed [COEF_W-1:0] left;
        logic signed [COEF_W-1:0] right;
    } coef_pair_t;

    typedef struct packed {
        logic advance;
        logic do_update;
    } upd_ctrl_t;

endpackage

[design/dgadv_cell.sv]
// One cell of the coefficient ring: holds a left/right pair and takes its
// neighbour's pair on every shift. Depends on dgadv_pkg.
module dgadv_cell
    import dgadv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       shift_en,
    input  coef_pair_t pair_in,
    output coef_pair_t pair_out
);

    coef_pair_t pair_reg;
    coef_pair_t pair_next;

    always_comb begin
        pair_next = shift_en ? pair_in : pair_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_reg <= '0;
        end else begin
            pair_reg <= pair_next;
        end
    end

    assign pair_out = pair_reg;

endmodule

[design/dgadv_update.sv]
// Two-stage Euler update datapath that sits in the ring between the head and
// tail cells: flux terms, scaled products, rounding and saturation. Uses dgadv_pkg.
module dgadv_update
    import dgadv_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic signed [VEL_W-1:0]  velocity,
    input  logic        [TS_W-1:0]   time_step,
    input  upd_ctrl_t                ctrl,
    input  coef_pair_t               head,
    input  logic signed [COEF_W-1:0] prev_right,
    output coef_pair_t               tail,
    output logic                     clip
);

    logic signed [K_W-1:0]    k_reg;
    logic signed [X_W-1:0]    xl_a_reg, xr_a_reg;
    coef_pair_t               old_a_reg;
    logic                     upd_a_reg;
    logic signed [PROD_W-1:0] pl_b_reg, pr_b_reg;
    coef_pair_t               old_b_reg;
    logic                     upd_b_reg;

    logic signed [S_W-1:0] s_sum;
    logic signed [D_W-1:0] d_diff;
    logic signed [X_W-1:0] xl_next, xr_next;
    logic signed [COEF_W-1:0] new_l, new_r;
    logic clip_l, clip_r;

    // Adds round(p / 2^36), ties away from zero, to old and clips to 16 bits.
    function automatic logic [COEF_W:0] round_sat(input logic signed [PROD_W-1:0] p,
                                                  input logic signed [COEF_W-1:0] old);
        logic [PROD_W-1:0]        biased;
        logic signed [INC_W-1:0]  inc;
        logic signed [SUM_W-1:0]  sum;
        logic signed [COEF_W-1:0] val;
        logic                     clipped;
        biased  = p + ROUND_HALF - PROD_W'(p[PROD_W-1]);
        inc     = $signed(biased[PROD_W-1:ROUND_SHIFT]);
        sum     = SUM_W'(old) + SUM_W'(inc);
        clipped = 1'b0;
        val     = sum[COEF_W-1:0];
        if (sum > SUM_W'(32767)) begin
            val     = 16'sh7fff;
            clipped = 1'b1;
        end else if (sum < -SUM_W'(32768)) begin
            val     = 16'sh8000;
            clipped = 1'b1;
        end
        return {clipped, val};
    endfunction

    always_comb begin
        s_sum   = (S_W'(prev_right) <<< 1) - S_W'(head.left) - S_W'(head.right);
        d_diff  = D_W'(head.left) - D_W'(head.right);
        xl_next = (X_W'(s_sum) <<< 1) - X_W'(d_diff);
        xr_next = (X_W'(d_diff) <<< 1) - X_W'(s_sum);
    end

    // Combined scale velocity * time_step, registered from the velocity and time_step inputs.
    always_ff @(posedge aclk) begin
        k_reg <= K_W'(velocity) * K_W'($signed({1'b0, time_step}));
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            xl_a_reg  <= xl_next;
            xr_a_reg  <= xr_next;
            old_a_reg <= head;
            pl_b_reg  <= PROD_W'(k_reg) * PROD_W'(xl_a_reg);
            pr_b_reg  <= PROD_W'(k_reg) * PROD_W'(xr_a_reg);
            old_b_reg <= old_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upd_a_reg <= 1'b0;
            upd_b_reg <= 1'b0;
        end else if (ctrl.advance) begin
            upd_a_reg <= ctrl.do_update;
            upd_b_reg <= upd_a_reg;
        end
    end

    always_comb begin
        {clip_l, new_l} = round_sat(pl_b_reg, old_b_reg.left);
        {clip_r, new_r} = round_sat(pr_b_reg, old_b_reg.right);
        if (upd_b_reg) begin
            tail.left  = new_l;
            tail.right = new_r;
        end else begin
            tail = old_b_reg;
        end
        clip = upd_b_reg & (clip_l | clip_r);
    end

endmodule

[design/dg_advection_euler_step_core.sv]
// Channel | Handshake          | Payload (lowest bit first)
// s_      | s_tvalid/s_tready  | tuser: cmd; tdata: cell_index, left_value, right_value
// m_      | m_tvalid/m_tready  | tdata: left_coef, right_coef; tuser: saturated
// cfg_    | cfg_valid/cfg_ready| cfg_index (0 velocity, 1 time_step), cfg_data
//
// After an item is accepted, the ring of cells and the two update stages rotate once all
// the way round, one cell through the shared multiply datapath per cycle, and then its
// result is ready. Loads and reads are taken as their cell passes the head. The next item
// is taken at the earliest in the cycle that result appears, even while that result waits.
// Reset clears all cells. A stalled result holds the last rotation step.
// Top level of the advection step core; depends on dgadv_pkg, dgadv_cell, dgadv_update.
`include "dg_advection_euler_step_core_defines.svh"
module dg_advection_euler_step_core
    import dgadv_pkg::*;
#(
    parameter int ELEMENTS = DEFAULT_ELEMENTS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // cell_index, left_value, right_value, zero fill
    input  logic [CMD_W-1:0]       s_tuser,   // cmd
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,   // left_coef, right_coef
    output logic [0:0]             m_tuser,   // saturated
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]      cfg_data
);

    localparam int CNT_W = $clog2(ELEMENTS + 2);
    localparam int CMP_W = (CNT_W > CELL_W) ? CNT_W : CELL_W;
    localparam logic [CNT_W-1:0] CNT_CELLS = CNT_W'(ELEMENTS);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(ELEMENTS + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                     state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CMD_W-1:0]         cmd_reg;
    logic [CELL_W-1:0]        idx_reg;
    coef_pair_t               load_reg;
    logic signed [COEF_W-1:0] prev_r_reg;
    coef_pair_t               rd_reg;
    logic                     sat_acc_reg;
    logic                     m_tvalid_reg;
    coef_pair_t               m_pair_reg;
    logic                     m_sat_reg;
    logic signed [VEL_W-1:0]  velocity_reg;
    logic        [TS_W-1:0]   time_step_reg;

    coef_pair_t cell_q [ELEMENTS];
    coef_pair_t cell_d [ELEMENTS];
    coef_pair_t head_in;
    coef_pair_t tail_out;
    upd_ctrl_t  upd_ctrl;
    logic       upd_clip;

    logic accept, busy, cnt_last, out_free, advance, in_cells, hit;

    always_comb begin
        accept   = s_tvalid && s_tready;
        busy     = (state_reg == ST_RUN);
        cnt_last = (cnt_reg == CNT_LAST);
        out_free = !m_tvalid_reg || m_tready;
        advance  = busy && (!cnt_last || out_free);
        in_cells = (cnt_reg < CNT_CELLS);
        hit      = in_cells && (CMP_W'(cnt_reg) == CMP_W'(idx_reg));

        head_in = cell_q[0];
        if (hit && (cmd_reg == CMD_LOAD)) begin
            head_in = load_reg;
        end
        upd_ctrl.advance   = advance;
        upd_ctrl.do_update = in_cells && (cmd_reg == CMD_STEP);

        state_next = state_reg;
        cnt_next   = cnt_reg;
        if (accept) begin
            state_next = ST_RUN;
            cnt_next   = '0;
        end else if (advance) begin
            if (cnt_last) begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end else begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    // The ring: cell k takes from cell k+1, the last cell from the update datapath.
    for (genvar k = 0; k < ELEMENTS; k++) begin : g_cell
        if (k == ELEMENTS - 1) begin : g_tail
            assign cell_d[k] = tail_out;
        end else begin : g_mid
            assign cell_d[k] = cell_q[k + 1];
        end
        dgadv_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (advance),
            .pair_in  (cell_d[k]),
            .pair_out (cell_q[k])
        );
    end

    dgadv_update u_update (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .velocity   (velocity_reg),
        .time_step  (time_step_reg),
        .ctrl       (upd_ctrl),
        .head       (head_in),
        .prev_right (prev_r_reg),
        .tail       (tail_out),
        .clip       (upd_clip)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
            sat_acc_reg   <= 1'b0;
            velocity_reg  <= VELOCITY_RESET;
            time_step_reg <= TIME_STEP_RESET;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (accept) begin
                sat_acc_reg <= 1'b0;
            end else if (advance && upd_clip) begin
                sat_acc_reg <= 1'b1;
            end
            if (advance && cnt_last) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_VELOCITY:  velocity_reg  <= $signed(cfg_data);
                    REG_TIME_STEP: time_step_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg        <= s_tuser;
            idx_reg        <= s_tdata[CELL_W-1:0];
            load_reg.left  <= $signed(s_tdata[CELL_W +: COEF_W]);
            load_reg.right <= $signed(s_tdata[CELL_W + COEF_W +: COEF_W]);
            rd_reg         <= '0;
            // At rest the last cell sits at the tail: its right value feeds cell 0.
            prev_r_reg     <= cell_q[ELEMENTS-1].right;
        end else if (advance && in_cells) begin
            prev_r_reg <= cell_q[0].right;
            if (hit && (cmd_reg == CMD_READ)) begin
                rd_reg <= cell_q[0];
            end
        end
        if (advance && cnt_last) begin
            m_pair_reg <= rd_reg;
            m_sat_reg  <= sat_acc_reg | upd_clip;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_pair_reg.right, m_pair_reg.left};
    assign m_tuser  = m_sat_reg;
    assign cfg_ready = 1'b1;

    `DGADV_ASSERT_IMP(a_accept_cnt_zero, aclk, aresetn, accept, cnt_reg == '0)
    `DGADV_ASSERT_NEXT(a_finish_gives_result, aclk, aresetn, advance && cnt_last, m_tvalid_reg)
    `DGADV_ASSERT_IMP(a_sat_only_step, aclk, aresetn, busy && sat_acc_reg, cmd_reg == CMD_STEP)
    `DGADV_ASSERT_IMP(a_cnt_in_range, aclk, aresetn, busy, cnt_reg <= CNT_LAST)

endmodule

[bench/dg_advection_euler_step_core_test.sv]
// Self-checking testbench for the advection step core: loads, reads and Euler steps
// are checked against a predictor of the cell grid kept inside the bench.
// Depends on dgadv_pkg and dg_advection_euler_step_core; reads no file.
module dg_advection_euler_step_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import dgadv_pkg::*;

    localparam int GRID_CELLS      = DEFAULT_ELEMENTS;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 155;
    localparam int DRAIN_CYCLES    = 2 * (GRID_CELLS + 2);
    localparam int CYCLE_LIMIT     = 1000000;
    localparam longint COEF_MAX    = 32767;
    localparam longint COEF_MIN    = -32768;

    localparam logic [CMD_W-1:0]       CMD_NOP      = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [CELL_W-1:0]        cell_idx;
        logic signed [COEF_W-1:0] left;
        logic signed [COEF_W-1:0] right;
    } grid_cmd_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] left;
        logic signed [COEF_W-1:0] right;
        logic                     saturated;
    } grid_reply_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic [CMD_W-1:0]       s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0]      cfg_data  = '0;

    // Bench copy of the grid and of the two registers.
    logic signed [COEF_W-1:0] left_cells  [GRID_CELLS];
    logic signed [COEF_W-1:0] right_cells [GRID_CELLS];
    logic signed [VEL_W-1:0]  vel_model = VELOCITY_RESET;
    logic        [TS_W-1:0]   ts_model  = TIME_STEP_RESET;

    grid_cmd_t   pending_q[$];
    grid_reply_t replies_due[$];
    grid_cmd_t   held_item;
    int          fail_count  = 0;
    int          cycle_count = 0;
    int          burst_left  = 0;
    int          gap_left    = 0;
    int          ready_run   = 0;

    dg_advection_euler_step_core #(
        .ELEMENTS(GRID_CELLS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // old + round(velocity * x * time_step / 2^36), ties away from zero, then clipped.
    function automatic logic signed [COEF_W-1:0] euler_term(
        input logic signed [COEF_W-1:0] old,
        input longint                   x,
        inout logic                     clip
    );
        longint vel_l, ts_l, prod, mag, sum;
        vel_l = vel_model;
        ts_l  = ts_model;
        prod  = vel_l * x * ts_l;
        mag   = (prod < 0) ? -prod : prod;
        mag   = (mag + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        sum   = old;
        sum   = sum + ((prod < 0) ? -mag : mag);
        if (sum > COEF_MAX) begin
            clip = 1'b1;
            return COEF_W'(COEF_MAX);
        end
        if (sum < COEF_MIN) begin
            clip = 1'b1;
            return COEF_W'(COEF_MIN);
        end
        return COEF_W'(sum);
    endfunction

    function automatic grid_reply_t grid_reply(input grid_cmd_t it);
        grid_reply_t rep;
        longint      prev, l, r, s, d;
        logic        clip;
        rep  = '0;
        clip = 1'b0;
        case (it.cmd)
            CMD_LOAD: begin
                left_cells[it.cell_idx]  = it.left;
                right_cells[it.cell_idx] = it.right;
            end
            CMD_STEP: begin
                // The flux into each cell uses the old right coefficient of its
                // left neighbour; the first cell wraps round to the last.
                prev = right_cells[GRID_CELLS-1];
                for (int i = 0; i < GRID_CELLS; i++) begin
                    l    = left_cells[i];
                    r    = right_cells[i];
                    s    = 2 * prev - l - r;
                    d    = l - r;
                    prev = r;
                    left_cells[i]  = euler_term(left_cells[i], 2 * s - d, clip);
                    right_cells[i] = euler_term(right_cells[i], 2 * d - s, clip);
                end
            end
            CMD_READ: begin
                rep.left  = left_cells[it.cell_idx];
                rep.right = right_cells[it.cell_idx];
            end
            default: begin
            end
        endcase
        rep.saturated = clip;
        return rep;
    endfunction

    function automatic logic signed [COEF_W-1:0] random_coef();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3, 4: return COEF_W'($urandom_range(0, 8191)) - 16'sd4096;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    function automatic grid_cmd_t random_item();
        grid_cmd_t   it;
        int unsigned pick;
        pick        = $urandom_range(0, 99);
        it.cell_idx = CELL_W'($urandom_range(0, GRID_CELLS - 1));
        it.left     = random_coef();
        it.right    = random_coef();
        if (pick < 40) begin
            it.cmd = CMD_LOAD;
        end else if (pick < 80) begin
            it.cmd = CMD_READ;
        end else if (pick < 94) begin
            it.cmd = CMD_STEP;
        end else begin
            it.cmd = CMD_NOP;
        end
        return it;
    endfunction

    function automatic grid_cmd_t make_item(
        input logic [CMD_W-1:0] cmd,
        input int               idx,
        input logic [COEF_W-1:0] left,
        input logic [COEF_W-1:0] right
    );
        grid_cmd_t it;
        it.cmd      = cmd;
        it.cell_idx = CELL_W'(idx);
        it.left     = left;
        it.right    = right;
        return it;
    endfunction

    task automatic write_setting(input logic [CFG_INDEX_W-1:0] idx, input logic [COEF_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_VELOCITY) begin
            vel_model = val;
        end else if (idx == REG_TIME_STEP) begin
            ts_model = val;
        end
    endtask

    // Waits until every queued item has been sent and every outstanding result has been taken.
    task automatic drain();
        while (pending_q.size() != 0 || s_tvalid || replies_due.size() != 0)
            @(posedge aclk);
    endtask

    // Sender: bursts of items with random gaps between them.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                replies_due.push_back(grid_reply(held_item));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    held_item = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= held_item.cmd;
                    s_tdata  <= {3'b000, held_item.right, held_item.left, held_item.cell_idx};
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end else begin
                        burst_left = burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: alternating runs of ready and stall of random length.
    always @(posedge aclk) begin
        if (ready_run == 0) begin
            if ($urandom_range(0, 2) != 0) begin
                m_tready <= 1'b1;
                ready_run = $urandom_range(1, 120);
            end else begin
                m_tready <= 1'b0;
                ready_run = $urandom_range(1, 50);
            end
        end else begin
            ready_run = ready_run - 1;
        end
    end

    always @(posedge aclk) begin
        grid_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (replies_due.size() == 0) begin
                $error("result item arrived with no expectation pending");
                fail_count++;
            end else begin
                want = replies_due.pop_front();
                if ($signed(m_tdata[15:0]) !== want.left) begin
                    $error("left_coef mismatch: expected %0d, got %0d",
                           want.left, $signed(m_tdata[15:0]));
                    fail_count++;
                end
                if ($signed(m_tdata[31:16]) !== want.right) begin
                    $error("right_coef mismatch: expected %0d, got %0d",
                           want.right, $signed(m_tdata[31:16]));
                    fail_count++;
                end
                if (m_tuser[0] !== want.saturated) begin
                    $error("saturated mismatch: expected %0d, got %0d",
                           want.saturated, m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < GRID_CELLS; i++) begin
            left_cells[i]  = '0;
            right_cells[i] = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset settings: cleared grid, extreme values at
        // both ends of the grid, the wrap from the first cell to the last, the
        // unused command and two steps.
        pending_q.push_back(make_item(CMD_READ, 0, 16'h1234, 16'h5678));
        pending_q.push_back(make_item(CMD_READ, GRID_CELLS - 1, 16'h0, 16'h0));
        pending_q.push_back(make_item(CMD_LOAD, 0, 16'h7FFF, 16'h8000));
        pending_q.push_back(make_item(CMD_LOAD, GRID_CELLS - 1, 16'h8000, 16'h7FFF));
        pending_q.push_back(make_item(CMD_LOAD, 1, 16'hFFFF, 16'h0000));
        pending_q.push_back(make_item(CMD_LOAD, 15, 16'h5555, 16'hAAAA));
        pending_q.push_back(make_item(CMD_READ, 0, 16'h0, 16'h0));
        pending_q.push_back(make_item(CMD_READ, GRID_CELLS - 1, 16'h0, 16'h0));
        pending_q.push_back(make_item(CMD_READ, 1, 16'hFFFF, 16'hFFFF));
        pending_q.push_back(make_item(CMD_NOP, GRID_CELLS - 1, 16'hFFFF, 16'hFFFF));
        pending_q.push_back(make_item(CMD_STEP, 0, 16'h0, 16'h0));
        pending_q.push_back(make_item(CMD_READ, 0, 16'h0, 16'h0));
        pending_q.push_back(make_item(CMD_READ, 1, 16'h0, 16'h0));
        pending_q.push_back(make_item(CMD_READ, 15, 16'h0, 16'h0));
        pending_q.push_back(make_item(CMD_READ, GRID_CELLS - 1, 16'h0, 16'h0));
        pending_q.push_back(make_item(CMD_LOAD, 2, 16'h0, 16'h0));
        pending_q.push_back(make_item(CMD_STEP, 31, 16'hFFFF, 16'hFFFF));
        pending_q.push_back(make_item(CMD_READ, 2, 16'h0, 16'h0));
        pending_q.push_back(make_item(CMD_READ, 0, 16'h0, 16'h0));
        pending_q.push_back(make_item(CMD_NOP, 0, 16'h0, 16'h0));
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    write_setting(REG_VELOCITY, 16'h7FFF);
                    write_setting(REG_TIME_STEP, 16'hFFFF);
                end
                1: begin
                    write_setting(REG_VELOCITY, 16'h8000);
                    write_setting(REG_TIME_STEP, 16'hFFFF);
                end
                2: begin
                    write_setting(REG_VELOCITY, 16'h0000);
                    write_setting(REG_TIME_STEP, COEF_W'($urandom));
                end
                3: begin
                    write_setting(REG_VELOCITY, COEF_W'($urandom));
                    write_setting(REG_TIME_STEP, 16'h0000);
                end
                4: begin
                    write_setting(REG_VELOCITY, 16'hFF00);
                    write_setting(REG_TIME_STEP, 16'd3000);
                    // Indexes past the register list must leave both registers alone.
                    write_setting(REG_SPARE_LO, COEF_W'($urandom));
                    write_setting(REG_SPARE_HI, COEF_W'($urandom));
                end
                5: begin
                    write_setting(REG_VELOCITY, COEF_W'($urandom));
                    write_setting(REG_TIME_STEP, COEF_W'($urandom_range(0, 4000)));
                end
                default: begin
                    write_setting(REG_VELOCITY, VELOCITY_RESET);
                    write_setting(REG_TIME_STEP, TIME_STEP_RESET);
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pending_q.push_back(random_item());
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
